[rtl/hbkd_pkg.sv]
// shared types, constants and the keycode tables of the boot keyboard decoder
package hbkd_pkg;

  localparam int NUM_SLOTS      = 6;
  localparam int CHAR_W         = 7;
  localparam int NUM_BANKS      = 8;
  localparam int BANK_BITS      = 3;
  localparam int FIFO_DEPTH_DEF = 64;
  localparam int MAIN_COUNT     = 53;
  localparam int PAD_BASE       = 85;
  localparam int PAD_COUNT      = 11;

  localparam logic [7:0] SHIFT_MASK = 8'h22;
  localparam logic [7:0] KEY_FIRST  = 8'h04;
  localparam logic [7:0] KEY_LIMIT  = 8'h64;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // first character sits in the top byte
  localparam logic [MAIN_COUNT*8-1:0] LOWER_MAIN =
    "abcdefghijklmnopqrstuvwxyz1234567890\015\033\010\011 -=[]\\#;'`,./";
  localparam logic [MAIN_COUNT*8-1:0] UPPER_MAIN =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()\015\033\010\011 _+{}|~:\"~<>?";
  localparam logic [PAD_COUNT*8-1:0] PAD_CHARS = "1234567890.";

  typedef logic [7:0]        key_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic       req_type;
    logic       report_ok;
    logic [7:0] modifiers;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              fifo_not_empty;
  } out_t;

  typedef struct packed {
    logic       push;
    logic [2:0] push_num;
    logic       pop;
  } fifo_req_t;

  // keycode to character, zero for keys with no character
  function automatic char_t map_key(input key_t kc, input logic shift);
    int         idx;
    logic [7:0] ch;
    idx = int'(kc) - int'(KEY_FIRST);
    ch  = 8'h00;
    if (idx >= 0 && idx < MAIN_COUNT) begin
      if (shift) begin
        ch = UPPER_MAIN[8*(MAIN_COUNT-1-idx) +: 8];
      end else begin
        ch = LOWER_MAIN[8*(MAIN_COUNT-1-idx) +: 8];
      end
    end else if (idx >= PAD_BASE && idx < PAD_BASE + PAD_COUNT) begin
      ch = PAD_CHARS[8*(PAD_COUNT-1-(idx-PAD_BASE)) +: 8];
    end
    return ch[CHAR_W-1:0];
  endfunction

endpackage

[rtl/hbkd_lane.sv]
// one slot lane: range check, repeat check against the previous report, table lookup
module hbkd_lane import hbkd_pkg::*; (
  input  key_t                  key_i,
  input  key_t [NUM_SLOTS-1:0]  prev_keys_i,
  input  logic                  shift_i,
  output char_t                 char_o,
  output logic                  hit_o
);

  logic  seen;
  logic  in_range;
  char_t ch;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (prev_keys_i[j] == key_i) begin
        seen = 1'b1;
      end
    end
  end

  assign in_range = (key_i >= KEY_FIRST) && (key_i < KEY_LIMIT);
  assign ch       = map_key(key_i, shift_i);
  assign char_o   = ch;
  assign hit_o    = in_range && !seen && (ch != '0);

endmodule

[rtl/hbkd_merge.sv]
// packs the lane hits into slot order, first hit first
module hbkd_merge import hbkd_pkg::*; (
  input  char_t [NUM_SLOTS-1:0] lane_char_i,
  input  logic  [NUM_SLOTS-1:0] lane_hit_i,
  output char_t [NUM_SLOTS-1:0] chars_o,
  output logic  [2:0]           num_o
);

  logic [2:0] pos [NUM_SLOTS];

  always_comb begin
    pos[0] = 3'd0;
    for (int i = 1; i < NUM_SLOTS; i++) begin
      pos[i] = pos[i-1] + {2'b00, lane_hit_i[i-1]};
    end
  end

  assign num_o = pos[NUM_SLOTS-1] + {2'b00, lane_hit_i[NUM_SLOTS-1]};

  always_comb begin
    chars_o = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (lane_hit_i[i] && pos[i] == 3'(k)) begin
          chars_o[k] = lane_char_i[i];
        end
      end
    end
  end

endmodule

[rtl/hbkd_fifo.sv]
// character fifo in eight interleaved banks, up to six writes and one read a cycle
module hbkd_fifo import hbkd_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fifo_req_t             req_i,
  input  char_t [NUM_SLOTS-1:0] chars_i,
  output logic                  pop_ok_o,
  output logic                  not_empty_next_o,
  output char_t                 rd_char_o
);

  localparam int ROWS_MIN = (FIFO_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
  localparam int RW       = (ROWS_MIN > 1) ? $clog2(ROWS_MIN) : 1;
  localparam int ROWS     = 2 ** RW;
  localparam int PW       = BANK_BITS + RW;
  localparam int CW       = $clog2(FIFO_DEPTH);
  localparam logic [CW-1:0] CAP = CW'(FIFO_DEPTH - 1);

  logic [PW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        free;
  logic [2:0]           n_wr;
  logic                 do_pop;
  logic [NUM_BANKS-1:0] bank_we;
  logic [RW-1:0]        bank_row [NUM_BANKS];
  char_t                bank_data [NUM_BANKS];
  char_t                rdata_q [NUM_BANKS];
  logic [BANK_BITS-1:0] rd_bank_q;
  logic [PW-1:0]        addr;

  assign free   = CAP - count_q;
  assign do_pop = req_i.pop && (count_q != '0);

  // characters past the last free entry are dropped
  always_comb begin
    n_wr = 3'd0;
    if (req_i.push) begin
      if ({3'b000, free} < {{CW{1'b0}}, req_i.push_num}) begin
        n_wr = 3'(free);
      end else begin
        n_wr = req_i.push_num;
      end
    end
  end

  // consecutive addresses land in distinct banks
  always_comb begin
    bank_we = '0;
    addr    = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_row[b]  = '0;
      bank_data[b] = '0;
    end
    for (int k = 0; k < NUM_SLOTS; k++) begin
      addr = wr_ptr_q + PW'(k);
      if (3'(k) < n_wr) begin
        bank_we[addr[BANK_BITS-1:0]]   = 1'b1;
        bank_row[addr[BANK_BITS-1:0]]  = addr[PW-1:BANK_BITS];
        bank_data[addr[BANK_BITS-1:0]] = chars_i[k];
      end
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    char_t mem [ROWS];

    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        mem[bank_row[b]] <= bank_data[b];
      end
    end

    always_ff @(posedge clk_i) begin
      if (do_pop && rd_ptr_q[BANK_BITS-1:0] == BANK_BITS'(b)) begin
        rdata_q[b] <= mem[rd_ptr_q[PW-1:BANK_BITS]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      rd_bank_q <= rd_ptr_q[BANK_BITS-1:0];
    end
  end

  assign rd_char_o = rdata_q[rd_bank_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(n_wr);
    rd_ptr_d = rd_ptr_q + PW'(do_pop);
    count_d  = count_q + CW'(n_wr) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign pop_ok_o         = do_pop;
  assign not_empty_next_o = (count_d != '0);

endmodule

[rtl/hid_boot_keyboard_decoder_unit.sv]
// HID boot keyboard decoder: takes one report or one read request every cycle while not stalled.
// Six slot lanes check and translate the keycodes of a report side by side, a merge stage packs
// the new characters in slot order, and all of them go into the character FIFO in the same cycle
// through eight interleaved storage banks, so the result of a report or a read shows up in the
// output register in the cycle after it is taken. The FIFO keeps at most FIFO_DEPTH-1 characters
// and drops any beyond that. Storage needs no clearing pass after reset.
module hid_boot_keyboard_decoder_unit import hbkd_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic                  in_xfer;
  logic                  report_take;
  logic                  shift;
  key_t  [NUM_SLOTS-1:0] slots;
  key_t  [NUM_SLOTS-1:0] prev_keys_q;
  char_t [NUM_SLOTS-1:0] lane_char;
  logic  [NUM_SLOTS-1:0] lane_hit;
  char_t [NUM_SLOTS-1:0] merged_chars;
  logic  [2:0]           merged_num;
  fifo_req_t             fifo_req;
  logic                  pop_ok;
  logic                  not_empty_next;
  char_t                 rd_char;
  logic                  out_valid_q;
  logic                  char_valid_q;
  logic                  not_empty_q;

  // output slot frees up when empty or being taken this cycle
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign report_take = in_xfer && (in_data_i.req_type == REQ_REPORT) && in_data_i.report_ok;

  assign slots = {in_data_i.key_slot_5, in_data_i.key_slot_4, in_data_i.key_slot_3,
                  in_data_i.key_slot_2, in_data_i.key_slot_1, in_data_i.key_slot_0};
  assign shift = |(in_data_i.modifiers & SHIFT_MASK);

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_lane
    hbkd_lane u_lane (
      .key_i       (slots[i]),
      .prev_keys_i (prev_keys_q),
      .shift_i     (shift),
      .char_o      (lane_char[i]),
      .hit_o       (lane_hit[i])
    );
  end

  hbkd_merge u_merge (
    .lane_char_i (lane_char),
    .lane_hit_i  (lane_hit),
    .chars_o     (merged_chars),
    .num_o       (merged_num)
  );

  always_comb begin
    fifo_req.push     = report_take;
    fifo_req.push_num = merged_num;
    fifo_req.pop      = in_xfer && (in_data_i.req_type == REQ_READ);
  end

  hbkd_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (fifo_req),
    .chars_i          (merged_chars),
    .pop_ok_o         (pop_ok),
    .not_empty_next_o (not_empty_next),
    .rd_char_o        (rd_char)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_keys_q  <= '0;
      out_valid_q  <= 1'b0;
      char_valid_q <= 1'b0;
      not_empty_q  <= 1'b0;
    end else begin
      if (report_take) begin
        prev_keys_q <= slots;
      end
      if (in_xfer) begin
        out_valid_q  <= 1'b1;
        char_valid_q <= pop_ok;
        not_empty_q  <= not_empty_next;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o               = out_valid_q;
  assign out_data_o.char_out       = char_valid_q ? rd_char : '0;
  assign out_data_o.char_valid     = char_valid_q;
  assign out_data_o.fifo_not_empty = not_empty_q;

endmodule

[dv/hid_boot_keyboard_decoder_unit_test.sv]
// self-checking testbench for the boot keyboard decoder, with its own model of the key fifo
module hid_boot_keyboard_decoder_unit_test;
  import hbkd_pkg::*;

  localparam int QUIET_TAIL = 60;
  localparam int RANDOM_REQUESTS = 450;

  localparam string LOWER_KEYS =
    "abcdefghijklmnopqrstuvwxyz1234567890\015\033\010\011 -=[]\\#;'`,./";
  localparam string UPPER_KEYS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()\015\033\010\011 _+{}|~:\"~<>?";
  localparam string KEYPAD_KEYS = "1234567890.";

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  hid_boot_keyboard_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  in_t  keyboard_requests[$];
  out_t char_results_due[$];

  // model state
  char_t      key_store [64];
  logic [5:0] store_wr = '0;
  logic [5:0] store_rd = '0;
  key_t       held_keys [NUM_SLOTS] = '{default: '0};

  int requests_made  = 0;
  int reports_taken  = 0;
  int reports_failed = 0;
  int reads_taken    = 0;
  int chars_returned = 0;
  int chars_dropped  = 0;
  int peak_fill      = 0;
  int mismatches     = 0;

  function automatic char_t key_char(input key_t kc, input logic shifted);
    int idx;
    idx = int'(kc) - int'(KEY_FIRST);
    if (idx < MAIN_COUNT) begin
      return shifted ? char_t'(UPPER_KEYS[idx]) : char_t'(LOWER_KEYS[idx]);
    end
    if (idx >= PAD_BASE && idx < PAD_BASE + PAD_COUNT) begin
      return char_t'(KEYPAD_KEYS[idx - PAD_BASE]);
    end
    return '0;
  endfunction

  task automatic decode_request(input in_t req);
    out_t       res;
    key_t       slots [NUM_SLOTS];
    key_t       kc;
    logic       shifted;
    logic       seen;
    char_t      ch;
    logic [5:0] nxt;
    res = '0;
    if (req.req_type == REQ_READ) begin
      reads_taken++;
      if (store_wr != store_rd) begin
        res.char_out   = key_store[store_rd];
        res.char_valid = 1'b1;
        store_rd++;
        chars_returned++;
      end
    end else if (!req.report_ok) begin
      reports_failed++;
    end else begin
      reports_taken++;
      slots = '{req.key_slot_0, req.key_slot_1, req.key_slot_2,
                req.key_slot_3, req.key_slot_4, req.key_slot_5};
      shifted = |(req.modifiers & SHIFT_MASK);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        kc   = slots[i];
        seen = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
          if (held_keys[j] == kc) seen = 1'b1;
        end
        if (kc >= KEY_FIRST && kc < KEY_LIMIT && !seen) begin
          ch = key_char(kc, shifted);
          if (ch != '0) begin
            nxt = store_wr + 6'd1;
            // one entry always stays free
            if (nxt != store_rd) begin
              key_store[store_wr] = ch;
              store_wr = nxt;
            end else begin
              chars_dropped++;
            end
          end
        end
      end
      held_keys = slots;
      if (int'(6'(store_wr - store_rd)) > peak_fill) peak_fill = int'(6'(store_wr - store_rd));
    end
    res.fifo_not_empty = (store_wr != store_rd);
    char_results_due.push_back(res);
  endtask

  // sender side
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_request(in_data_i);
        void'(keyboard_requests.pop_front());
      end
      // a stalled transfer keeps its payload
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (keyboard_requests.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= keyboard_requests[0];
          if (keyboard_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 19);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver side
  int   stall_left = 0;
  out_t due;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (char_results_due.size() == 0) begin
          $display("%0t: result with nothing due: %p", $time, out_data_o);
          mismatches++;
        end else begin
          due = char_results_due.pop_front();
          if (out_data_o.char_out !== due.char_out) begin
            $display("%0t: char_out expected %h got %h", $time, due.char_out,
                     out_data_o.char_out);
            mismatches++;
          end
          if (out_data_o.char_valid !== due.char_valid) begin
            $display("%0t: char_valid expected %b got %b", $time, due.char_valid,
                     out_data_o.char_valid);
            mismatches++;
          end
          if (out_data_o.fifo_not_empty !== due.fifo_not_empty) begin
            $display("%0t: fifo_not_empty expected %b got %b", $time, due.fifo_not_empty,
                     out_data_o.fifo_not_empty);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (keyboard_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 19);
        end
      end
    end
  end

  task automatic queue_report(input logic ok, input logic [7:0] mods, input logic [47:0] slots);
    in_t req;
    req.req_type   = REQ_REPORT;
    req.report_ok  = ok;
    req.modifiers  = mods;
    {req.key_slot_0, req.key_slot_1, req.key_slot_2,
     req.key_slot_3, req.key_slot_4, req.key_slot_5} = slots;
    keyboard_requests.push_back(req);
    requests_made++;
  endtask

  task automatic queue_read();
    in_t         req;
    logic [63:0] raw;
    // the ignored fields carry noise
    raw = {$urandom, $urandom};
    req = raw[$bits(in_t)-1:0];
    req.req_type = REQ_READ;
    keyboard_requests.push_back(req);
    requests_made++;
  endtask

  function automatic key_t typed_key();
    if ($urandom_range(0, 3) == 0) return key_t'($urandom_range(8'h59, 8'h63));
    return key_t'($urandom_range(8'h04, 8'h38));
  endfunction

  initial begin
    logic [47:0] slots;
    logic [7:0]  mods;
    int          target;
    int          reps;
    int          density;

    // directed: empty read, failed report, range edges, shift bits, repeats, filling the fifo to full
    queue_read();
    queue_report(1'b0, 8'h00, 48'h04_05_06_00_00_00);
    queue_report(1'b1, 8'h00, 48'h04_00_03_64_ff_1d);
    queue_report(1'b1, 8'h00, 48'h04_05_00_00_00_00);
    queue_report(1'b1, 8'h02, 48'h1e_1f_20_21_22_23);
    queue_report(1'b1, 8'h20, 48'h28_29_2a_2b_2c_2d);
    queue_report(1'b1, 8'hdd, 48'h2e_2f_30_31_32_33);
    queue_report(1'b1, 8'hff, 48'h34_35_36_37_38_39);
    queue_report(1'b1, 8'h00, 48'h3a_4f_58_57_40_50);
    queue_report(1'b1, 8'h22, 48'h59_5a_5b_5c_5d_5e);
    queue_report(1'b1, 8'h00, 48'h5f_60_61_62_63_11);
    queue_report(1'b1, 8'h00, 48'h07_07_07_07_07_07);
    queue_report(1'b1, 8'h00, 48'h00_00_00_00_00_00);
    queue_report(1'b0, 8'h02, 48'h08_00_00_00_00_00);
    queue_report(1'b1, 8'h02, 48'h08_00_00_00_00_00);
    queue_report(1'b1, 8'h00, 48'h09_0a_0b_0c_0d_0e);
    queue_report(1'b1, 8'h00, 48'h0f_10_11_12_13_14);
    queue_report(1'b1, 8'h02, 48'h15_16_17_18_19_1a);
    repeat (7) queue_read();

    target = requests_made + RANDOM_REQUESTS;
    while (requests_made < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // ordinary typing with reads in between
          reps = $urandom_range(1, 8);
          density = $urandom_range(1, 5);
          repeat (reps) begin
            slots = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if ($urandom_range(0, 5) < density) slots[47-8*i -: 8] = typed_key();
            end
            mods = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) mods &= ~SHIFT_MASK;
            queue_report($urandom_range(0, 9) != 0, mods, slots);
            repeat ($urandom_range(0, 2)) queue_read();
          end
        end
        5, 6: begin
          // full reports with no reads, pushes the fifo to full
          reps = $urandom_range(6, 14);
          repeat (reps) begin
            for (int i = 0; i < NUM_SLOTS; i++) slots[47-8*i -: 8] = typed_key();
            queue_report(1'b1, 8'($urandom_range(0, 255)), slots);
          end
        end
        7, 8: begin
          repeat ($urandom_range(1, 40)) queue_read();
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            queue_report(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         {$urandom, 16'($urandom)});
          end
        end
      endcase
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (keyboard_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    while (char_results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d accepted reports, %0d failed reports, %0d reads returning %0d chars",
             reports_taken, reports_failed, reads_taken, chars_returned);
    $display("%0d chars dropped on a full fifo, deepest fill %0d", chars_dropped, peak_fill);
    if (mismatches == 0) begin
      $display("** hid_boot_keyboard_decoder_unit: PASSED **");
    end else begin
      $display("** hid_boot_keyboard_decoder_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timed out with %0d requests unsent and %0d results due",
             keyboard_requests.size(), char_results_due.size());
    $display("** hid_boot_keyboard_decoder_unit: FAILED **");
    $finish;
  end

endmodule

[sim.f]
rtl/hbkd_pkg.sv
rtl/hbkd_lane.sv
rtl/hbkd_merge.sv
rtl/hbkd_fifo.sv
rtl/hid_boot_keyboard_decoder_unit.sv
dv/hid_boot_keyboard_decoder_unit_test.sv
